>>> src/rcs_pkg.sv
package rcs_pkg;

  typedef enum logic [1:0] {
    OP_SPLAT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_MAP_WIDTH   = 2'd0,
    CFG_MAP_HEIGHT  = 2'd1,
    CFG_BASE_HEIGHT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_OUT,
    S_CLR,
    S_POS,
    S_TEST,
    S_SQRT,
    S_MUL,
    S_DIV,
    S_WB
  } state_e;

  localparam logic [7:0]         RESET_MAP_WIDTH   = 8'd128;
  localparam logic [7:0]         RESET_MAP_HEIGHT  = 8'd128;
  localparam logic signed [15:0] RESET_BASE_HEIGHT = -16'sd1000;

endpackage

>>> src/rcs_ram.sv
module rcs_ram #(
  parameter int Width = 32,
  parameter int Depth = 16384
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/radial_cone_heightmap_splat.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    opcode_i pos_x_i pos_y_i peak_height_i radius_i
// out      output     out_valid_o / out_ready_i  cell_height_o
// cfg      input      cfg_we_i (no wait)         cfg_index_i cfg_data_i
//
// One item is worked on at a time; the height store is a single memory
// with a registered read, and every cell update is a read, compute, write.
// A read waits in its output step until the output register is free. A clear
// writes the map in use, one write per cycle. A splat visits each of the
// (2r+1)^2 offsets in a position step and a test step; each in-map cell inside
// the cone then runs the bit-per-step square root, a multiply, the bit-per-step
// divider and a write-back. Reset clears control and configuration but not
// the store: cells are undefined until a clear or splat writes them. An item
// is taken while a result still waits for out_ready_i, unless the item is a
// read, which then holds in the output step until the slot frees.
module radial_cone_heightmap_splat #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 128,
  parameter int MAX_RADIUS  = 63
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [6:0]         pos_x_i,
  input  logic [6:0]         pos_y_i,
  input  logic signed [15:0] peak_height_i,
  input  logic [5:0]         radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] cell_height_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW   = $clog2(MAX_COLUMNS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int OW    = RW + 1;
  localparam int B1    = (CNW > RNW) ? CNW : RNW;
  localparam int B2    = (B1 > 7) ? B1 : 7;
  localparam int B3    = (B2 > RW) ? B2 : RW;
  localparam int XW    = B3 + 2;
  localparam int SQW   = 2 * RW + 1;
  localparam int VW    = SQW + 16;
  localparam int VWE   = VW + (VW % 2);
  localparam int SQS   = VWE / 2;
  localparam int RTW   = SQS;
  localparam int SPW   = RW + 8;
  localparam int PW    = SPW + 16;
  localparam int CTW   = $clog2(PW + 1);

  // Configuration registers.
  logic [7:0]         map_width_q, map_height_q;
  logic signed [15:0] base_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q   <= rcs_pkg::RESET_MAP_WIDTH;
      map_height_q  <= rcs_pkg::RESET_MAP_HEIGHT;
      base_height_q <= rcs_pkg::RESET_BASE_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (rcs_pkg::cfg_index_e'(cfg_index_i))
        rcs_pkg::CFG_MAP_WIDTH:   map_width_q   <= cfg_data_i[7:0];
        rcs_pkg::CFG_MAP_HEIGHT:  map_height_q  <= cfg_data_i[7:0];
        rcs_pkg::CFG_BASE_HEIGHT: base_height_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The area in use is the configured size clamped to the store.
  logic [CNW-1:0] cols_used;
  logic [RNW-1:0] rows_used;
  assign cols_used = (32'(map_width_q) > MAX_COLUMNS) ? CNW'(MAX_COLUMNS) : CNW'(map_width_q);
  assign rows_used = (32'(map_height_q) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(map_height_q);

  rcs_pkg::state_e state_q, state_d;

  // Splat and clear working registers.
  logic [6:0]           cx_q, cy_q;
  logic signed [15:0]   peak_q;
  logic [RW-1:0]        r_q;
  logic signed [OW-1:0] oi_q, oj_q;
  logic [AW-1:0]        addr_q;
  logic                 hit_q;
  logic [SQW-1:0]       sq_q;
  logic [VWE-1:0]       v_q;
  logic [RTW-1:0]       root_q;
  logic [RTW:0]         rem_q;
  logic [CTW-1:0]       cnt_q;
  logic [PW-1:0]        prod_q;
  logic [RW-1:0]        drem_q;
  logic                 neg_q;
  logic [CIW-1:0]       clr_x_q;
  logic [RIW-1:0]       clr_y_q;
  logic                 rd_in_q;
  logic                 out_valid_q;
  logic signed [31:0]   cell_height_q;

  // Input decode.
  logic                 accept;
  rcs_pkg::opcode_e     op_in;
  logic [8:0]           rad_ext, rad_sat;
  logic [RW-1:0]        r_in;
  logic                 rd_inb;
  logic [AW-1:0]        rd_addr;

  assign accept  = in_valid_i && in_ready_o;
  assign op_in   = rcs_pkg::opcode_e'(opcode_i);
  assign rad_ext = 9'(radius_i);
  assign rad_sat = (rad_ext > 9'(MAX_RADIUS)) ? 9'(MAX_RADIUS) : rad_ext;
  assign r_in    = rad_sat[RW-1:0];
  assign rd_inb  = (XW'(pos_x_i) < XW'(cols_used)) && (XW'(pos_y_i) < XW'(rows_used));
  assign rd_addr = AW'(AW'(pos_x_i) * AW'(MAX_ROWS) + AW'(pos_y_i));

  // Cone offset walk: the cell position, its bounds and squared distance.
  logic signed [XW-1:0]   px, py;
  logic                   pos_inb;
  logic [2*OW-1:0]        sq_i, sq_j, sq_full, rr;
  logic [AW-1:0]          pos_addr;
  logic                   last_cell;
  logic signed [OW-1:0]   r_s, oi_next, oj_next;

  assign px       = $signed(XW'({1'b0, cx_q})) + XW'(oi_q);
  assign py       = $signed(XW'({1'b0, cy_q})) + XW'(oj_q);
  assign pos_inb  = (px >= 0) && (py >= 0) &&
                    (px < $signed(XW'(cols_used))) && (py < $signed(XW'(rows_used)));
  assign sq_i     = $unsigned((2*OW)'(oi_q) * (2*OW)'(oi_q));
  assign sq_j     = $unsigned((2*OW)'(oj_q) * (2*OW)'(oj_q));
  assign sq_full  = sq_i + sq_j;
  assign rr       = (2*OW)'(r_q) * (2*OW)'(r_q);
  assign pos_addr = AW'(AW'($unsigned(px)) * AW'(MAX_ROWS) + AW'($unsigned(py)));
  assign r_s      = $signed({1'b0, r_q});
  assign last_cell = (oi_q == r_s) && (oj_q == r_s);
  assign oj_next  = (oj_q == r_s) ? -r_s : oj_q + OW'(1);
  assign oi_next  = (oj_q == r_s) ? oi_q + OW'(1) : oi_q;

  // One digit pair of the square root per cycle.
  logic [RTW+2:0] sq_t, sq_trial;
  logic           sq_ge;
  assign sq_t     = {rem_q, v_q[VWE-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  // Span times peak magnitude.
  logic [SPW-1:0] span;
  logic [15:0]    peak_mag;
  assign span     = {r_q, 8'b0} - SPW'(root_q);
  assign peak_mag = peak_q[15] ? 16'(-peak_q) : 16'(peak_q);

  // One quotient bit of the division by the radius per cycle.
  logic [RW:0] dv_t;
  logic        dv_ge;
  assign dv_t  = {drem_q, prod_q[PW-1]};
  assign dv_ge = dv_t >= {1'b0, r_q};

  // Saturating add of the cone amount to the stored cell.
  logic [31:0]        ram_rdata;
  logic signed [33:0] dz, sum;
  logic signed [31:0] sat_val;
  assign dz      = neg_q ? -$signed(34'(prod_q)) : $signed(34'(prod_q));
  assign sum     = $signed({{2{ram_rdata[31]}}, ram_rdata}) + dz;
  assign sat_val = (sum > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                   (sum < -34'sh0_8000_0000) ? 32'sh8000_0000 : sum[31:0];

  logic clr_last;
  assign clr_last = (CNW'(clr_x_q) == cols_used - CNW'(1)) &&
                    (RNW'(clr_y_q) == rows_used - RNW'(1));

  logic signed [31:0] clr_val;
  assign clr_val = {{8{base_height_q[15]}}, base_height_q, 8'b0};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcs_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op_in)
            rcs_pkg::OP_SPLAT: if (r_in != '0) state_d = rcs_pkg::S_POS;
            rcs_pkg::OP_READ:  state_d = rcs_pkg::S_RD_OUT;
            rcs_pkg::OP_CLEAR: begin
              if (cols_used != '0 && rows_used != '0) state_d = rcs_pkg::S_CLR;
            end
            default: ;
          endcase
        end
      end
      rcs_pkg::S_RD_OUT: if (!out_valid_q || out_ready_i) state_d = rcs_pkg::S_IDLE;
      rcs_pkg::S_CLR:    if (clr_last) state_d = rcs_pkg::S_IDLE;
      rcs_pkg::S_POS:    state_d = rcs_pkg::S_TEST;
      rcs_pkg::S_TEST: begin
        if (hit_q)          state_d = rcs_pkg::S_SQRT;
        else if (last_cell) state_d = rcs_pkg::S_IDLE;
        else                state_d = rcs_pkg::S_POS;
      end
      rcs_pkg::S_SQRT: if (cnt_q == CTW'(SQS - 1)) state_d = rcs_pkg::S_MUL;
      rcs_pkg::S_MUL:  state_d = rcs_pkg::S_DIV;
      rcs_pkg::S_DIV:  if (cnt_q == CTW'(PW - 1)) state_d = rcs_pkg::S_WB;
      rcs_pkg::S_WB:   state_d = last_cell ? rcs_pkg::S_IDLE : rcs_pkg::S_POS;
      default:         state_d = rcs_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory port controls.
  logic          ram_we, ram_re, out_load;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata;

  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = addr_q;
    ram_raddr  = addr_q;
    ram_wdata  = sat_val;
    out_load   = 1'b0;
    unique case (state_q)
      rcs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        ram_raddr  = rd_addr;
        ram_re     = in_valid_i && (op_in == rcs_pkg::OP_READ) && rd_inb;
      end
      rcs_pkg::S_RD_OUT: out_load = !out_valid_q || out_ready_i;
      rcs_pkg::S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(AW'(clr_x_q) * AW'(MAX_ROWS) + AW'(clr_y_q));
        ram_wdata = clr_val;
      end
      rcs_pkg::S_TEST: ram_re = hit_q;
      rcs_pkg::S_WB:   ram_we = 1'b1;
      default: ;
    endcase
  end

  rcs_ram #(
    .Width (32),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcs_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers; none of them needs a reset.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cell_height_q <= rd_in_q ? $signed(ram_rdata) : 32'sd0;
    end
    unique case (state_q)
      rcs_pkg::S_IDLE: begin
        cx_q    <= pos_x_i;
        cy_q    <= pos_y_i;
        peak_q  <= peak_height_i;
        r_q     <= r_in;
        oi_q    <= -$signed({1'b0, r_in});
        oj_q    <= -$signed({1'b0, r_in});
        rd_in_q <= rd_inb;
        clr_x_q <= '0;
        clr_y_q <= '0;
      end
      rcs_pkg::S_CLR: begin
        if (RNW'(clr_y_q) == rows_used - RNW'(1)) begin
          clr_y_q <= '0;
          clr_x_q <= clr_x_q + CIW'(1);
        end else begin
          clr_y_q <= clr_y_q + RIW'(1);
        end
      end
      rcs_pkg::S_POS: begin
        hit_q  <= pos_inb && (sq_full <= rr);
        sq_q   <= SQW'(sq_full);
        addr_q <= pos_addr;
      end
      rcs_pkg::S_TEST: begin
        v_q    <= VWE'({sq_q, 16'b0});
        root_q <= '0;
        rem_q  <= '0;
        cnt_q  <= '0;
        if (!hit_q) begin
          oi_q <= oi_next;
          oj_q <= oj_next;
        end
      end
      rcs_pkg::S_SQRT: begin
        v_q   <= {v_q[VWE-3:0], 2'b00};
        cnt_q <= cnt_q + CTW'(1);
        if (sq_ge) begin
          rem_q  <= (RTW+1)'(sq_t - sq_trial);
          root_q <= {root_q[RTW-2:0], 1'b1};
        end else begin
          rem_q  <= (RTW+1)'(sq_t);
          root_q <= {root_q[RTW-2:0], 1'b0};
        end
      end
      rcs_pkg::S_MUL: begin
        prod_q <= PW'(span) * PW'(peak_mag);
        neg_q  <= peak_q[15];
        drem_q <= '0;
        cnt_q  <= '0;
      end
      rcs_pkg::S_DIV: begin
        cnt_q  <= cnt_q + CTW'(1);
        prod_q <= {prod_q[PW-2:0], dv_ge};
        drem_q <= dv_ge ? RW'(dv_t - {1'b0, r_q}) : dv_t[RW-1:0];
      end
      rcs_pkg::S_WB: begin
        oi_q <= oi_next;
        oj_q <= oj_next;
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign cell_height_o = cell_height_q;

`ifndef NO_ASSERTIONS
  // The store port never reads and writes in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store read and write in the same cycle");

  // A cone cell that hits is always read before its square root starts.
  a_hit_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcs_pkg::S_TEST && hit_q) |=> (state_q == rcs_pkg::S_SQRT))
    else $error("cone cell hit did not start its update");

  // A read result is only loaded when the output register is free.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // Clear writes stay inside the area in use.
  a_clr_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcs_pkg::S_CLR) |->
      ((CNW'(clr_x_q) < cols_used) && (RNW'(clr_y_q) < rows_used)))
    else $error("clear write outside the map");
`endif

endmodule

>>> tb/sv/tb_top.sv
module tb_top;

  // The run stops here if the block hangs. The slowest correct run stays
  // well below this limit, so it leaves a wide margin.
  localparam int CYCLE_LIMIT = 20000000;
  localparam int NUM_COLS    = 128;
  localparam int NUM_ROWS    = 128;
  localparam int RADIUS_CAP  = 63;
  localparam int DIR_ROWS    = 25;

  // Cycles allowed after the last read result before touching registers.
  localparam int SETTLE_CYCLES = 4;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         opcode_i;
  logic [6:0]         pos_x_i;
  logic [6:0]         pos_y_i;
  logic signed [15:0] peak_height_i;
  logic [5:0]         radius_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] cell_height_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;

  radial_cone_heightmap_splat u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .peak_height_i (peak_height_i),
    .radius_i      (radius_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cell_height_o (cell_height_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the height map and the registers that the predictor
  // keeps in step with every accepted item and every register write.
  logic signed [31:0] shadow_cells [NUM_COLS*NUM_ROWS];
  logic [7:0]         shadow_width;
  logic [7:0]         shadow_height;
  logic signed [15:0] shadow_base;

  // Cell heights still owed by the block, oldest first.
  logic signed [31:0] pending_heights [$];

  int  fail_count;
  int  cycle_count;
  int  items_sent;
  int  reads_checked;
  int  splats_sent;
  int  clears_sent;
  int  sender_idle_pct;
  int  receiver_idle_pct;

  // One row of the directed table. A row either writes a register or sends
  // an item; typed rows carry the read result that is obvious by inspection.
  typedef struct packed {
    logic                  is_cfg;
    rcs_pkg::cfg_index_e   reg_index;
    logic [15:0]           reg_value;
    rcs_pkg::opcode_e      op;
    logic [6:0]            x;
    logic [6:0]            y;
    logic signed [15:0]    peak;
    logic [5:0]            radius;
    logic                  typed;
    logic signed [31:0]    typed_height;
  } dir_row_t;

  dir_row_t dir_table [DIR_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter doubles as the hang detector.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The receiver side: out_ready_i changes only at falling edges, with the
  // stall rate set by the current phase.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Every accepted result is compared with the oldest expected height.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_heights.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d", $time, cell_height_o);
        fail_count++;
      end else begin
        if (cell_height_o !== pending_heights[0]) begin
          $display("%0t cell_height mismatch: expected %0d, actual %0d",
                   $time, pending_heights[0], cell_height_o);
          fail_count++;
        end
        reads_checked++;
        void'(pending_heights.pop_front());
      end
    end
  end

  function automatic int used_cols();
    return (shadow_width > NUM_COLS) ? NUM_COLS : int'(shadow_width);
  endfunction

  function automatic int used_rows();
    return (shadow_height > NUM_ROWS) ? NUM_ROWS : int'(shadow_height);
  endfunction

  // Floor of the square root, one result bit per step.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] add_clamped(logic signed [31:0] a, longint b);
    longint s;
    s = longint'(a) + b;
    if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // Adds one cone to the shadow map. Distances carry 8 fraction bits and the
  // cone amount is truncated toward zero, as SystemVerilog division does.
  function automatic void add_cone(int cx, int cy, longint peak, longint r);
    int      cols;
    int      rows;
    longint  x;
    longint  y;
    longint  cone_dist;
    longint  dz;
    cols = used_cols();
    rows = used_rows();
    if (r > RADIUS_CAP) r = RADIUS_CAP;
    if (r == 0) return;
    for (longint i = -r; i <= r; i++) begin
      for (longint j = -r; j <= r; j++) begin
        x = cx + i;
        y = cy + j;
        if (x >= 0 && x < cols && y >= 0 && y < rows && i*i + j*j <= r*r) begin
          cone_dist = longint'(floor_root(longint'(i*i + j*j) << 16));
          dz = ((r * 256 - cone_dist) * peak) / r;
          shadow_cells[x*NUM_ROWS + y] = add_clamped(shadow_cells[x*NUM_ROWS + y], dz);
        end
      end
    end
  endfunction

  // Advances the shadow state by one item and returns the height a read
  // yields. Only reads produce a result.
  function automatic logic signed [31:0] predict_item(rcs_pkg::opcode_e op, int x, int y,
                                                      logic signed [15:0] peak, int r);
    logic signed [31:0] height;
    height = '0;
    unique case (op)
      rcs_pkg::OP_SPLAT: begin
        add_cone(x, y, longint'(peak), longint'(r));
      end
      rcs_pkg::OP_READ: begin
        if (x < used_cols() && y < used_rows()) height = shadow_cells[x*NUM_ROWS + y];
      end
      rcs_pkg::OP_CLEAR: begin
        for (int cx = 0; cx < used_cols(); cx++)
          for (int cy = 0; cy < used_rows(); cy++)
            shadow_cells[cx*NUM_ROWS + cy] = 32'(shadow_base) * 256;
      end
      default: ;
    endcase
    return height;
  endfunction

  // Presents one item, holding it until the block takes it. Each cycle in
  // front of it the sender may stay idle, at the rate of the current phase.
  task automatic send_item(rcs_pkg::opcode_e op, int x, int y, logic signed [15:0] peak,
                           int r, logic typed, logic signed [31:0] typed_height);
    logic signed [31:0] height;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    opcode_i      = op;
    pos_x_i       = x[6:0];
    pos_y_i       = y[6:0];
    peak_height_i = peak;
    radius_i      = r[5:0];
    do @(posedge clk_i); while (!in_ready_o);
    height = predict_item(op, x, y, peak, r);
    if (op == rcs_pkg::OP_READ) pending_heights.push_back(typed ? typed_height : height);
    if (op == rcs_pkg::OP_SPLAT) splats_sent++;
    if (op == rcs_pkg::OP_CLEAR) clears_sent++;
    items_sent++;
  endtask

  // Holds the sender off until every owed result is in. A trailing read
  // proves that any splat or clear ahead of it is finished too.
  task automatic drain_block();
    send_item(rcs_pkg::OP_READ, 0, 0, 16'sd0, 0, 1'b0, '0);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_heights.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(rcs_pkg::cfg_index_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    unique case (idx)
      rcs_pkg::CFG_MAP_WIDTH:   shadow_width  = value[7:0];
      rcs_pkg::CFG_MAP_HEIGHT:  shadow_height = value[7:0];
      rcs_pkg::CFG_BASE_HEIGHT: shadow_base   = value;
      default: ;
    endcase
  endtask

  function automatic dir_row_t item_row(rcs_pkg::opcode_e op, int x, int y, int peak, int r);
    dir_row_t row;
    row        = '0;
    row.op     = op;
    row.x      = x[6:0];
    row.y      = y[6:0];
    row.peak   = peak[15:0];
    row.radius = r[5:0];
    return row;
  endfunction

  function automatic dir_row_t typed_read(int x, int y, int height);
    dir_row_t row;
    row              = item_row(rcs_pkg::OP_READ, x, y, 0, 0);
    row.typed        = 1'b1;
    row.typed_height = height;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(rcs_pkg::cfg_index_e idx, int value);
    dir_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.reg_index = idx;
    row.reg_value = value[15:0];
    return row;
  endfunction

  // Random register set for one phase. Most maps are small so that clears
  // and cones stay cheap; now and then the map is full size or empty.
  task automatic random_setup();
    int w;
    int h;
    w = ($urandom_range(0, 9) == 0) ? 128 : $urandom_range(1, 16);
    h = ($urandom_range(0, 9) == 0) ? 128 : $urandom_range(1, 16);
    if ($urandom_range(0, 19) == 0) w = 0;
    drain_block();
    write_reg(rcs_pkg::CFG_MAP_WIDTH, 16'(w));
    write_reg(rcs_pkg::CFG_MAP_HEIGHT, 16'(h));
    write_reg(rcs_pkg::CFG_BASE_HEIGHT, 16'($urandom));
    // Every cell in use is written before anything reads or adds to it.
    send_item(rcs_pkg::OP_CLEAR, 0, 0, 16'sd0, 0, 1'b0, '0);
  endtask

  // One random item, aimed mostly inside the map in use.
  task automatic random_item();
    int                pick;
    int                x;
    int                y;
    int                r;
    rcs_pkg::opcode_e  op;
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = rcs_pkg::OP_SPLAT;
    else if (pick < 85) op = rcs_pkg::OP_READ;
    else if (pick < 92) op = rcs_pkg::OP_CLEAR;
    else                op = rcs_pkg::OP_NONE;
    if (used_cols() > 0 && used_rows() > 0 && $urandom_range(0, 3) != 0) begin
      x = $urandom_range(0, used_cols() - 1);
      y = $urandom_range(0, used_rows() - 1);
    end else begin
      x = $urandom_range(0, 127);
      y = $urandom_range(0, 127);
    end
    // Big cones only on small maps, where few cells fall inside them.
    if (used_cols() * used_rows() <= 256 && $urandom_range(0, 19) == 0)
      r = $urandom_range(32, 63);
    else
      r = $urandom_range(0, 8);
    send_item(op, x, y, 16'($urandom), r, 1'b0, '0);
  endtask

  initial begin
    fail_count        = 0;
    cycle_count       = 0;
    items_sent        = 0;
    reads_checked     = 0;
    splats_sent       = 0;
    clears_sent       = 0;
    sender_idle_pct   = 32;
    receiver_idle_pct = 48;
    in_valid_i        = 1'b0;
    opcode_i          = rcs_pkg::OP_NONE;
    pos_x_i           = '0;
    pos_y_i           = '0;
    peak_height_i     = '0;
    radius_i          = '0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = rcs_pkg::CFG_MAP_WIDTH;
    cfg_data_i        = '0;
    shadow_width      = rcs_pkg::RESET_MAP_WIDTH;
    shadow_height     = rcs_pkg::RESET_MAP_HEIGHT;
    shadow_base       = rcs_pkg::RESET_BASE_HEIGHT;
    foreach (shadow_cells[k]) shadow_cells[k] = '0;

    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. With the reset registers a clear puts -1000 in whole
    // units (-256000 in Q24.8) everywhere; later rows cover the corners, the
    // peak extremes, a zero radius, the unused opcode, an empty map, reads
    // outside the map and the largest radius on a tiny map.
    dir_table[0]  = item_row(rcs_pkg::OP_CLEAR, 0, 0, 0, 0);
    dir_table[1]  = typed_read(0, 0, -256000);
    dir_table[2]  = typed_read(127, 127, -256000);
    dir_table[3]  = item_row(rcs_pkg::OP_SPLAT, 0, 0, 32767, 1);
    dir_table[4]  = item_row(rcs_pkg::OP_READ, 0, 0, 0, 0);
    dir_table[5]  = item_row(rcs_pkg::OP_READ, 1, 0, 0, 0);
    dir_table[6]  = item_row(rcs_pkg::OP_SPLAT, 127, 127, -32768, 2);
    dir_table[7]  = item_row(rcs_pkg::OP_READ, 127, 126, 0, 0);
    dir_table[8]  = item_row(rcs_pkg::OP_SPLAT, 3, 3, 1234, 0);
    dir_table[9]  = typed_read(3, 3, -256000);
    dir_table[10] = item_row(rcs_pkg::OP_NONE, 9, 9, -1, 63);
    dir_table[11] = cfg_row(rcs_pkg::CFG_MAP_WIDTH, 0);
    dir_table[12] = item_row(rcs_pkg::OP_CLEAR, 0, 0, 0, 0);
    dir_table[13] = typed_read(0, 0, 0);
    dir_table[14] = cfg_row(rcs_pkg::CFG_MAP_WIDTH, 3);
    dir_table[15] = cfg_row(rcs_pkg::CFG_MAP_HEIGHT, 2);
    dir_table[16] = cfg_row(rcs_pkg::CFG_BASE_HEIGHT, 16'h8000);
    dir_table[17] = cfg_row(rcs_pkg::CFG_UNUSED, 16'hFFFF);
    dir_table[18] = item_row(rcs_pkg::OP_CLEAR, 0, 0, 0, 0);
    dir_table[19] = typed_read(2, 1, -8388608);
    dir_table[20] = typed_read(3, 1, 0);
    dir_table[21] = typed_read(0, 127, 0);
    dir_table[22] = item_row(rcs_pkg::OP_SPLAT, 1, 1, -32768, 63);
    dir_table[23] = item_row(rcs_pkg::OP_READ, 1, 1, 0, 0);
    dir_table[24] = item_row(rcs_pkg::OP_READ, 0, 0, 0, 0);

    foreach (dir_table[k]) begin
      if (dir_table[k].is_cfg) begin
        if (k == 0 || !dir_table[k-1].is_cfg) drain_block();
        write_reg(dir_table[k].reg_index, dir_table[k].reg_value);
      end else begin
        send_item(dir_table[k].op, dir_table[k].x, dir_table[k].y, dir_table[k].peak,
                  dir_table[k].radius, dir_table[k].typed, dir_table[k].typed_height);
      end
    end

    // Width above the limit is clamped to the full map; the largest base
    // height lands in the far corner.
    drain_block();
    write_reg(rcs_pkg::CFG_MAP_WIDTH, 16'h00FF);
    write_reg(rcs_pkg::CFG_MAP_HEIGHT, 16'd128);
    write_reg(rcs_pkg::CFG_BASE_HEIGHT, 16'h7FFF);
    send_item(rcs_pkg::OP_CLEAR, 0, 0, 16'sd0, 0, 1'b0, '0);
    send_item(rcs_pkg::OP_READ, 127, 127, 16'sd0, 0, 1'b1, 32'sd8388352);

    // Random part in three phases: sender idles less than the receiver,
    // then the other way round, then neither idles.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 32 : (phase == 1) ? 48 : 0;
      receiver_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 32 : 0;
      random_setup();
      for (int n = 0; n < 22; n++) begin
        if (n == 11) random_setup();
        random_item();
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_heights.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d items (%0d splats, %0d clears) over several map sizes and idle mixes.",
             items_sent, splats_sent, clears_sent);
    $display("Checked %0d read results, %0d mismatching.", reads_checked, fail_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
src/rcs_pkg.sv
src/rcs_ram.sv
src/radial_cone_heightmap_splat.sv
tb/sv/tb_top.sv
